/* src/hsvw_pkg.sv */
// Shared widths, constants and sector codes of the HSV color-wheel converter.
package hsvw_pkg;

    // Field widths of the request and result payloads.
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 9;
    localparam int BRI_W  = 9;
    localparam int CHAN_W = 8;

    // Default fixed-point formats.
    localparam int HUE_FRAC_BITS_DEF  = 6;
    localparam int UNIT_FRAC_BITS_DEF = 8;

    // Geometry of the wheel and the full-scale channel value.
    localparam int SECTOR_DEG   = 60;
    localparam int SECTOR_COUNT = 6;
    localparam int CHAN_MAX     = 255;

    // Sector codes, named after the hue range that each one spans.
    typedef logic [2:0] sector_t;
    localparam sector_t SEC_RED_YELLOW   = 3'd0;
    localparam sector_t SEC_YELLOW_GREEN = 3'd1;
    localparam sector_t SEC_GREEN_CYAN   = 3'd2;
    localparam sector_t SEC_CYAN_BLUE    = 3'd3;
    localparam sector_t SEC_BLUE_MAGENTA = 3'd4;
    localparam sector_t SEC_MAGENTA_RED  = 3'd5;

endpackage

/* src/hsvw_in_if.sv */
// Request channel of the converter: hue, saturation and brightness.
interface hsvw_in_if;

    logic                          valid;
    logic                          ready;
    logic [hsvw_pkg::HUE_W-1:0]    hue;
    logic [hsvw_pkg::SAT_W-1:0]    saturation;
    logic [hsvw_pkg::BRI_W-1:0]    brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);

endinterface

/* src/hsvw_out_if.sv */
// Result channel of the converter: 8-bit red, green and blue.
interface hsvw_out_if;

    logic                          valid;
    logic                          ready;
    logic [hsvw_pkg::CHAN_W-1:0]   red;
    logic [hsvw_pkg::CHAN_W-1:0]   green;
    logic [hsvw_pkg::CHAN_W-1:0]   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

/* src/hsv_to_rgb_wheel.sv */
// Pipelined converter from a color-wheel point (hue, saturation, brightness) to RGB.
//
// Usage:
//   Requests enter on the hsv channel (valid/ready): hue in 1/64 degree (any
//   16-bit value, taken modulo a full turn), saturation and brightness in Q8,
//   where 256 is 1.0 and larger values saturate. Each request yields exactly
//   one result on the rgb channel (valid/ready) with truncated 8-bit channels.
//   The datapath is an eight-stage pipeline; while the receiver does not stall,
//   a new request is taken in every cycle, so the sustained rate is one pixel
//   per clock. The longest stage paths are the hue reciprocal multiply, the
//   ramp products and the final reciprocal multiply that divides by the
//   sector span.
//   Every stage carries a valid bit and moves only when it is empty or the stage
//   after it moves, so a stall of the receiver fills bubbles first and then
//   drops ready on the hsv channel; no request is lost or repeated.
//   Reset (rst_n low, asynchronous) empties the pipeline; ready is high right
//   after reset. There is no configuration and no state between requests.
module hsv_to_rgb_wheel #(
    parameter int HUE_FRAC_BITS  = hsvw_pkg::HUE_FRAC_BITS_DEF,
    parameter int UNIT_FRAC_BITS = hsvw_pkg::UNIT_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    hsvw_in_if.sink           hsv,
    hsvw_out_if.source        rgb
);

    // ---------------------------------------------------------------------------------
    // Derived constants.
    // ---------------------------------------------------------------------------------
    localparam int STAGES = 8;
    localparam int HW     = hsvw_pkg::HUE_W;
    localparam int CHW    = hsvw_pkg::CHAN_W;
    localparam int UF     = UNIT_FRAC_BITS;
    localparam int UW     = UF + 1;
    localparam int SATCW  = (hsvw_pkg::SAT_W > UW) ? hsvw_pkg::SAT_W : UW;
    localparam int BRICW  = (hsvw_pkg::BRI_W > UW) ? hsvw_pkg::BRI_W : UW;
    localparam int SECW   = $clog2(hsvw_pkg::SECTOR_COUNT);

    localparam longint unsigned SPAN = 64'(hsvw_pkg::SECTOR_DEG) << HUE_FRAC_BITS;
    localparam longint unsigned ONE  = 64'd1 << UF;
    localparam int SPW = $clog2(SPAN + 1);

    // Reciprocal of the sector span for a 16-bit hue (exact floor division).
    localparam int              S_H  = HW + $clog2(SPAN);
    localparam longint unsigned M_H  = ((64'd1 << S_H) + SPAN - 1) / SPAN;
    localparam int              MHW  = $clog2(M_H + 1);
    localparam longint unsigned QMAX = ((64'd1 << HW) - 1) / SPAN;
    localparam int              QW   = $clog2(QMAX + 1);

    // Reciprocal of the sector count for the sector index modulo six.
    localparam int              S_6  = QW + SECW;
    localparam longint unsigned M_6  = ((64'd1 << S_6) + hsvw_pkg::SECTOR_COUNT - 1)
                                       / hsvw_pkg::SECTOR_COUNT;
    localparam int              M6W  = $clog2(M_6 + 1);

    // Ramp datapath widths.
    localparam int              TW   = $clog2(SPAN * ONE + 1);
    localparam int              PW   = TW + UW;
    localparam int              ISW  = 2 * UF + 1;
    localparam longint unsigned YMAX = 64'(hsvw_pkg::CHAN_MAX) * SPAN;
    localparam int              YW   = $clog2(YMAX + 1);

    // Reciprocal of the sector span for the scaled ramp numerator.
    localparam int              S_Y  = YW + $clog2(SPAN);
    localparam longint unsigned M_Y  = ((64'd1 << S_Y) + SPAN - 1) / SPAN;
    localparam int              MYW  = $clog2(M_Y + 1);

    // ---------------------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or the next one advances.
    // ---------------------------------------------------------------------------------
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] adv;
    logic [STAGES:0] vchain;

    always_comb
    begin
        adv[STAGES] = !valid_reg[STAGES] || rgb.ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k + 1];
        end
        vchain = {valid_reg, hsv.valid};
    end

    assign hsv.ready = adv[1];
    assign rgb.valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= vchain[k - 1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 1: clamp radius and scale, coarse sector index by reciprocal multiply.
    // ---------------------------------------------------------------------------------
    logic [SATCW-1:0]   sat_ext;
    logic [BRICW-1:0]   bri_ext;
    logic [UW-1:0]      rad1_next;
    logic [UW-1:0]      scl1_next;
    logic [HW+MHW-1:0]  hprod;
    logic [QW-1:0]      qa1_next;
    logic [HW-1:0]      hue1_reg;
    logic [QW-1:0]      qa1_reg;
    logic [UW-1:0]      rad1_reg;
    logic [UW-1:0]      scl1_reg;

    always_comb
    begin
        sat_ext   = SATCW'(hsv.saturation);
        bri_ext   = BRICW'(hsv.brightness);
        rad1_next = (sat_ext > SATCW'(ONE)) ? UW'(ONE) : UW'(sat_ext);
        scl1_next = (bri_ext > BRICW'(ONE)) ? UW'(ONE) : UW'(bri_ext);
        hprod     = (HW+MHW)'(hsv.hue) * (HW+MHW)'(M_H);
        qa1_next  = QW'(hprod >> S_H);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            hue1_reg <= hsv.hue;
            qa1_reg  <= qa1_next;
            rad1_reg <= rad1_next;
            scl1_reg <= scl1_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 2: offset inside the sector, and the quotient of the index by six.
    // ---------------------------------------------------------------------------------
    logic [HW-1:0]      base2;
    logic [SPW-1:0]     off2_next;
    logic [QW+M6W-1:0]  q6prod;
    logic [QW-1:0]      q62_next;
    logic [SPW-1:0]     off2_reg;
    logic [QW-1:0]      qa2_reg;
    logic [QW-1:0]      q62_reg;
    logic [UW-1:0]      rad2_reg;
    logic [UW-1:0]      scl2_reg;

    always_comb
    begin
        base2     = HW'(HW'(qa1_reg) * HW'(SPAN));
        off2_next = SPW'(hue1_reg - base2);
        q6prod    = (QW+M6W)'(qa1_reg) * (QW+M6W)'(M_6);
        q62_next  = QW'(q6prod >> S_6);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            off2_reg <= off2_next;
            qa2_reg  <= qa1_reg;
            q62_reg  <= q62_next;
            rad2_reg <= rad1_reg;
            scl2_reg <= scl1_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 3: sector number, ramp position and inverted radius.
    // ---------------------------------------------------------------------------------
    hsvw_pkg::sector_t  sec3_next;
    logic [SPW-1:0]     num3_next;
    logic [UW-1:0]      inv3_next;
    hsvw_pkg::sector_t  sec3_reg;
    logic [SPW-1:0]     num3_reg;
    logic [UW-1:0]      inv3_reg;
    logic [UW-1:0]      scl3_reg;

    always_comb
    begin
        sec3_next = SECW'(qa2_reg - QW'(QW'(q62_reg) * QW'(hsvw_pkg::SECTOR_COUNT)));
        // The ramp rises in even sectors and falls in odd ones.
        num3_next = sec3_next[0] ? (SPW'(SPAN) - off2_reg) : off2_reg;
        inv3_next = UW'(ONE) - rad2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sec3_reg <= sec3_next;
            num3_reg <= num3_next;
            inv3_reg <= inv3_next;
            scl3_reg <= scl2_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 4: ramp blend, inverted-radius and scale product, and the dominant channel.
    // ---------------------------------------------------------------------------------
    logic [TW-1:0]      t4_next;
    logic [ISW-1:0]     is4_next;
    logic [UW+7:0]      dom_prod;
    logic [CHW-1:0]     dom4_next;
    logic [TW-1:0]      t4_reg;
    logic [ISW-1:0]     is4_reg;
    logic [CHW-1:0]     dom4_reg;
    logic [UW-1:0]      scl4_reg;
    hsvw_pkg::sector_t  sec4_reg;

    always_comb
    begin
        t4_next   = (TW'(num3_reg) << UF)
                  + TW'(TW'(SPW'(SPAN) - num3_reg) * TW'(inv3_reg));
        is4_next  = ISW'(inv3_reg) * ISW'(scl3_reg);
        dom_prod  = (UW+8)'(scl3_reg) * (UW+8)'(hsvw_pkg::CHAN_MAX);
        dom4_next = CHW'(dom_prod >> UF);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            t4_reg   <= t4_next;
            is4_reg  <= is4_next;
            dom4_reg <= dom4_next;
            scl4_reg <= scl3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 5: scale the ramp blend, finish the falling channel.
    // ---------------------------------------------------------------------------------
    logic [PW-1:0]      p5_next;
    logic [ISW+7:0]     fall_prod;
    logic [CHW-1:0]     fall5_next;
    logic [PW-1:0]      p5_reg;
    logic [CHW-1:0]     fall5_reg;
    logic [CHW-1:0]     dom5_reg;
    hsvw_pkg::sector_t  sec5_reg;

    always_comb
    begin
        p5_next    = PW'(t4_reg) * PW'(scl4_reg);
        fall_prod  = (ISW+8)'(is4_reg) * (ISW+8)'(hsvw_pkg::CHAN_MAX);
        fall5_next = CHW'(fall_prod >> (2 * UF));
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            p5_reg    <= p5_next;
            fall5_reg <= fall5_next;
            dom5_reg  <= dom4_reg;
            sec5_reg  <= sec4_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 6: apply full scale and drop the two unit fractions.
    // ---------------------------------------------------------------------------------
    logic [PW+7:0]      y_prod;
    logic [YW-1:0]      y6_next;
    logic [YW-1:0]      y6_reg;
    logic [CHW-1:0]     fall6_reg;
    logic [CHW-1:0]     dom6_reg;
    hsvw_pkg::sector_t  sec6_reg;

    always_comb
    begin
        y_prod  = (PW+8)'(p5_reg) * (PW+8)'(hsvw_pkg::CHAN_MAX);
        y6_next = YW'(y_prod >> (2 * UF));
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            y6_reg    <= y6_next;
            fall6_reg <= fall5_reg;
            dom6_reg  <= dom5_reg;
            sec6_reg  <= sec5_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 7: divide by the sector span through its reciprocal.
    // ---------------------------------------------------------------------------------
    logic [YW+MYW-1:0]  r_prod;
    logic [CHW-1:0]     ramp7_next;
    logic [CHW-1:0]     ramp7_reg;
    logic [CHW-1:0]     fall7_reg;
    logic [CHW-1:0]     dom7_reg;
    hsvw_pkg::sector_t  sec7_reg;

    always_comb
    begin
        r_prod     = (YW+MYW)'(y6_reg) * (YW+MYW)'(M_Y);
        ramp7_next = CHW'(r_prod >> S_Y);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            ramp7_reg <= ramp7_next;
            fall7_reg <= fall6_reg;
            dom7_reg  <= dom6_reg;
            sec7_reg  <= sec6_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 8: route the three levels to red, green and blue by sector.
    // ---------------------------------------------------------------------------------
    logic [CHW-1:0] red_next;
    logic [CHW-1:0] green_next;
    logic [CHW-1:0] blue_next;
    logic [CHW-1:0] red_reg;
    logic [CHW-1:0] green_reg;
    logic [CHW-1:0] blue_reg;

    always_comb
    begin
        unique case (sec7_reg)
            hsvw_pkg::SEC_RED_YELLOW:
            begin
                red_next = dom7_reg;  green_next = ramp7_reg; blue_next = fall7_reg;
            end
            hsvw_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = ramp7_reg; green_next = dom7_reg;  blue_next = fall7_reg;
            end
            hsvw_pkg::SEC_GREEN_CYAN:
            begin
                red_next = fall7_reg; green_next = dom7_reg;  blue_next = ramp7_reg;
            end
            hsvw_pkg::SEC_CYAN_BLUE:
            begin
                red_next = fall7_reg; green_next = ramp7_reg; blue_next = dom7_reg;
            end
            hsvw_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = ramp7_reg; green_next = fall7_reg; blue_next = dom7_reg;
            end
            default:
            begin
                red_next = dom7_reg;  green_next = fall7_reg; blue_next = ramp7_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

    // ---------------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------------

    // An empty output stage lets every stage move, so a request is always taken.
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STAGES] |-> hsv.ready)
        else $error("request refused while the output stage is empty");

    // A full pipeline with a stalled receiver must refuse new requests.
    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !rgb.ready) |-> !hsv.ready)
        else $error("request taken while the full pipeline is stalled");

    // The offset stays inside its sector.
    a_offset_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (off2_reg < SPW'(SPAN)))
        else $error("sector offset out of range");

    // The index reduction modulo six gives a real sector.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (sec3_reg <= hsvw_pkg::SEC_MAGENTA_RED))
        else $error("sector number out of range");

    // The dominant level bounds the ramp and the falling level.
    a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[7] |-> (ramp7_reg <= dom7_reg && fall7_reg <= ramp7_reg))
        else $error("channel levels out of order");

endmodule
